[rtl/itc_pkg.sv]
// package for the three-counter interval timer
// types, codes and sizes shared by itc_counter and interval_timer_three_counter
package itc_pkg;

  localparam int NumCounters = 3;

  localparam int OpW     = 2;
  localparam int PortW   = 2;
  localparam int ByteW   = 8;
  localparam int CountW  = 16;
  localparam int ModeW   = 3;
  localparam int InDataW = 16;

  localparam logic [PortW-1:0] CtrlPort = 2'd3;
  localparam logic [1:0]       RlLatch  = 2'd0;
  localparam logic [1:0]       RlLsb    = 2'd1;
  localparam logic [1:0]       RlMsb    = 2'd2;
  localparam logic [ByteW-1:0] NoData   = 8'hFF;

  typedef enum logic [OpW-1:0] {
    OpTick  = 2'd0,
    OpRead  = 2'd1,
    OpWrite = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    PhLsb   = 2'd0,
    PhMsb   = 2'd1,
    PhWordL = 2'd2,
    PhWordM = 2'd3
  } phase_e;

  typedef struct packed {
    logic             tick;
    logic             rd;
    logic             wr;
    logic             ctl;
    logic [ByteW-1:0] data;
  } cnt_cmd_t;

endpackage

[rtl/itc_counter.sv]
// one down counter of the interval timer: load, elapsed counts, latch, byte order
// depends on itc_pkg
module itc_counter import itc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cnt_cmd_t         cmd_i,
  output logic [ByteW-1:0] rd_byte_o
);

  logic [CountW-1:0] load_q, load_d;
  logic [CountW-1:0] free_q, free_d;
  logic [CountW-1:0] per_q, per_d;
  logic [CountW-1:0] hold_q, hold_d;
  logic [ByteW-1:0]  low_q, low_d;
  logic [ModeW-1:0]  mode_q, mode_d;
  phase_e            rph_q, rph_d;
  phase_e            wph_q, wph_d;
  logic              hval_q, hval_d;

  logic [CountW-1:0] live;
  logic [CountW-1:0] rd_word;
  logic [CountW:0]   per_inc;

  always_comb begin
    if (mode_q[1]) begin
      if (load_q != '0) begin
        live = load_q - per_q;
      end else begin
        live = CountW'(0) - free_q;
      end
    end else begin
      live = load_q - free_q;
    end
    rd_word = hval_q ? hold_q : live;
    case (rph_q)
      PhLsb, PhWordL: rd_byte_o = rd_word[ByteW-1:0];
      default:        rd_byte_o = rd_word[CountW-1:ByteW];
    endcase
  end

  assign per_inc = {1'b0, per_q} + (CountW+1)'(1);

  always_comb begin
    load_d = load_q;
    free_d = free_q;
    per_d  = per_q;
    hold_d = hold_q;
    low_d  = low_q;
    mode_d = mode_q;
    rph_d  = rph_q;
    wph_d  = wph_q;
    hval_d = hval_q;

    if (cmd_i.tick) begin
      free_d = free_q + CountW'(1);
      if (load_q == '0 || per_inc >= {1'b0, load_q}) begin
        per_d = '0;
      end else begin
        per_d = per_inc[CountW-1:0];
      end
    end

    if (cmd_i.rd) begin
      if (hval_q && rph_q != PhWordL) begin
        hval_d = 1'b0;
      end
      case (rph_q)
        PhWordL: rph_d = PhWordM;
        PhWordM: rph_d = PhWordL;
        default: rph_d = rph_q;
      endcase
    end

    if (cmd_i.ctl) begin
      case (cmd_i.data[5:4])
        RlLatch: begin
          hold_d = live;
          hval_d = 1'b1;
        end
        RlLsb: begin
          mode_d = cmd_i.data[3:1];
          rph_d  = PhLsb;
          wph_d  = PhLsb;
        end
        RlMsb: begin
          mode_d = cmd_i.data[3:1];
          rph_d  = PhMsb;
          wph_d  = PhMsb;
        end
        default: begin
          mode_d = cmd_i.data[3:1];
          rph_d  = PhWordL;
          wph_d  = PhWordL;
        end
      endcase
    end

    if (cmd_i.wr) begin
      if (wph_q == PhWordL) begin
        low_d = cmd_i.data;
        wph_d = PhWordM;
      end else begin
        free_d = '0;
        per_d  = '0;
        case (wph_q)
          PhLsb:   load_d = {load_q[CountW-1:ByteW], cmd_i.data};
          PhMsb:   load_d = {cmd_i.data, load_q[ByteW-1:0]};
          default: begin
            load_d = {cmd_i.data, low_q};
            rph_d  = PhWordL;
            wph_d  = PhWordL;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
      free_q <= '0;
      per_q  <= '0;
      hold_q <= '0;
      low_q  <= '0;
      mode_q <= '0;
      rph_q  <= PhLsb;
      wph_q  <= PhLsb;
      hval_q <= 1'b0;
    end else begin
      load_q <= load_d;
      free_q <= free_d;
      per_q  <= per_d;
      hold_q <= hold_d;
      low_q  <= low_d;
      mode_q <= mode_d;
      rph_q  <= rph_d;
      wph_q  <= wph_d;
      hval_q <= hval_d;
    end
  end

endmodule

[rtl/interval_timer_three_counter.sv]
// top level of the three-counter interval timer: input register, counters, result register
// depends on itc_pkg and itc_counter
//
//   channel   dir  fields (low bit up)                      when
//   s_axis    in   opcode[1:0] port[3:2] data[11:4] pad     tick, port read or port write
//   m_axis    out  read_data[7:0]                           one item per port read
//
// one item per cycle unless m_axis stalls; reads pass the input, then the result register
// the counters update between the input register and the result register
// reset clears every counter, the byte orders and both valid flags
// a stalled result register holds the input register, which then drops s_axis_tready
module interval_timer_three_counter import itc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [InDataW-1:0] s_axis_tdata,   // opcode[1:0], port[3:2], data[11:4], zeros
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [ByteW-1:0]   m_axis_tdata    // read_data[7:0]
);

  logic             in_valid_q, in_valid_d;
  logic [OpW-1:0]   op_q;
  logic [PortW-1:0] port_q;
  logic [ByteW-1:0] data_q;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_data_q, out_data_d;
  logic             fire;
  logic             out_free;
  logic             is_read;
  logic             is_write;
  logic [ByteW-1:0] rd_sel;

  cnt_cmd_t         cmd   [NumCounters];
  logic [ByteW-1:0] rd_byte [NumCounters];

  assign out_free      = !out_valid_q || m_axis_tready;
  assign fire          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || fire;
  assign is_read       = (op_q == OpRead);
  assign is_write      = (op_q == OpWrite);

  for (genvar i = 0; i < NumCounters; i++) begin : g_cnt
    always_comb begin
      cmd[i].tick = fire && (op_q == OpTick);
      cmd[i].rd   = fire && is_read && (port_q == PortW'(i));
      cmd[i].wr   = fire && is_write && (port_q == PortW'(i));
      cmd[i].ctl  = fire && is_write && (port_q == CtrlPort) && (data_q[7:6] == 2'(i));
      cmd[i].data = data_q;
    end

    itc_counter u_counter (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd[i]),
      .rd_byte_o (rd_byte[i])
    );
  end

  always_comb begin
    rd_sel = NoData;
    for (int i = 0; i < NumCounters; i++) begin
      if (port_q == PortW'(i)) begin
        rd_sel = rd_byte[i];
      end
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (fire && is_read) begin
      out_valid_d = 1'b1;
      out_data_d  = rd_sel;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      op_q   <= s_axis_tdata[OpW-1:0];
      port_q <= s_axis_tdata[OpW+PortW-1:OpW];
      data_q <= s_axis_tdata[OpW+PortW+ByteW-1:OpW+PortW];
    end
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule
